@@ hdl/xsg_pkg.sv @@
// ----------------------------------------------------------------------------
// xsg_pkg: shared types and constants of the xoshiro stream generator
// Request codes, the sequencer state type and the mixing constants.
// ----------------------------------------------------------------------------
`default_nettype none
package xsg_pkg;

  localparam logic [63:0] GoldenGamma = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMulA     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB     = 64'h94d049bb133111eb;

  localparam logic [1:0] ReqSeed   = 2'd0;
  localparam logic [1:0] ReqRaw    = 2'd1;
  localparam logic [1:0] ReqRanged = 2'd2;
  localparam logic [1:0] ReqNone   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,      // serial multiply: prod = ma * mb
    ST_SEED_MIX, // step through the seeding chain
    ST_DRAW,     // one xoshiro step
    ST_LIM,      // serial remainder for the unbiased limit
    ST_TEST,     // rejection test
    ST_MOD,      // serial remainder of the draw
    ST_OUT       // not entered; a result waits in the output register
  } xsg_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] domain_hash;
    logic [63:0] instance_number;
    logic [63:0] range_low;
    logic [63:0] range_high;
  } xsg_req_t;

  typedef struct packed {
    logic [63:0] value;
    logic [63:0] draw_count;
  } xsg_rsp_t;

endpackage
`default_nettype wire

@@ hdl/xsg_stream_if.sv @@
// ----------------------------------------------------------------------------
// xsg_stream_if: valid/ready channel
// Carries one payload of type T per accepted request.
// ----------------------------------------------------------------------------
`default_nettype none
interface xsg_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/xsg_divider.sv @@
// ----------------------------------------------------------------------------
// xsg_divider: bit-serial 64-bit remainder
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module xsg_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [63:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      rem_o
);
  logic [63:0] num_q, num_d, rem_q, rem_d, dsr_q, dsr_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [64:0] trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    trial  = {rem_q, num_q[63]} - {1'b0, dsr_q};
    if (start_i) begin
      num_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract if it fits
      num_d = {num_q[62:0], 1'b0};
      if (!trial[64]) rem_d = trial[63:0];
      else rem_d = {rem_q[62:0], num_q[63]};
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
      end
    end else if (cnt_q == 7'd64) begin
      done_o = 1'b1;
      cnt_d  = '0;
    end
  end

  assign rem_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end
endmodule
`default_nettype wire

@@ hdl/xoshiro_stream_generator.sv @@
// ----------------------------------------------------------------------------
// xoshiro_stream_generator: xoshiro256++ stream with SplitMix64 seeding
// Handles seed, raw draw and ranged draw requests one at a time.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (valid/ready), results leave on rsp, one
// result per request except the unused request code, which is dropped.
// The root seed register is written over the APB port at address 0; the
// user must write it only while idle, the block itself does not enforce it.
// A raw draw takes one xoshiro step; an empty range returns range_low and a
// full span is served as a raw draw. Seeding runs nine serial 64x64 multiplies
// through a 16-bit digit-serial multiplier, each followed by a mixing step; a
// ranged draw makes two passes of the bit-serial remainder unit, one quotient
// bit per cycle, and each rejected draw repeats the draw and rejection test.
// One request is in flight at a time; req ready is low while busy and while
// a result waits, so the next request is taken the cycle after the result
// leaves. The unused request code is taken and dropped; the block stays idle.
// The result sits in an output register; while the receiver stalls, the
// block holds it and takes no new request.
// Reset clears the state words, the draw count and the root seed; a seed
// request must come first, since the all-zero state draws zero forever.
`default_nettype none
module xoshiro_stream_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  xsg_stream_if.sink       req,
  xsg_stream_if.source     rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import xsg_pkg::*;

  xsg_state_e  state_q, state_d;
  logic [63:0] root_q;
  logic [63:0] s0_q, s1_q, s2_q, s3_q, s0_d, s1_d, s2_d, s3_d;
  logic [63:0] cnt_q, cnt_d;
  logic [63:0] lo_q, lo_d, span_q, span_d, lim_q, lim_d, d_q, d_d;
  logic [63:0] acc_q, acc_d, val_q, val_d;
  logic [1:0]  type_q, type_d;
  logic [3:0]  step_q, step_d;   // seeding sequence step
  logic [63:0] ma_q, ma_d, mb_q, mb_d, prod_q, prod_d;
  logic [1:0]  dig_q, dig_d;
  logic        out_v_q, out_v_d;
  logic        dv_start;
  logic [63:0] dv_num, dv_den, dv_rem;
  logic        dv_done;
  logic [63:0] draw_res, z, span_w;
  logic [79:0] pp;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? root_q : '0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) root_q <= '0;
    else if (psel && penable && pwrite && paddr == 3'd0) root_q <= pwdata;
  end

  assign req.ready = (state_q == ST_IDLE) && !out_v_q;
  assign rsp.valid = out_v_q;
  assign rsp.data  = '{value: val_q, draw_count: cnt_q};

  assign draw_res = {s0_q + s3_q} << 23 | (s0_q + s3_q) >> 41;
  assign span_w   = req.data.range_high - req.data.range_low + 64'd1;
  // one 64x16 partial product per cycle
  assign pp = ma_q * mb_q[dig_q*16 +: 16];

  xsg_divider u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .dividend_i(dv_num),
    .divisor_i(dv_den), .done_o(dv_done), .rem_o(dv_rem)
  );

  // next state and datapath
  always_comb begin
    state_d = state_q;
    {s0_d, s1_d, s2_d, s3_d} = {s0_q, s1_q, s2_q, s3_q};
    cnt_d = cnt_q; lo_d = lo_q; span_d = span_q; lim_d = lim_q; d_d = d_q;
    acc_d = acc_q; val_d = val_q; type_d = type_q; step_d = step_q;
    ma_d = ma_q; mb_d = mb_q; prod_d = prod_q; dig_d = dig_q;
    out_v_d = out_v_q;
    dv_start = 1'b0; dv_num = d_q; dv_den = span_q;
    z = prod_q;
    if (rsp.valid && rsp.ready) out_v_d = 1'b0;
    case (state_q)
      ST_IDLE: if (req.valid && req.ready) begin
        type_d = req.data.req_type;
        lo_d   = req.data.range_low;
        span_d = span_w;
        acc_d  = root_q ^ req.data.domain_hash;
        case (req.data.req_type)
          ReqSeed: begin
            ma_d = req.data.instance_number; mb_d = GoldenGamma;
            prod_d = '0; dig_d = '0; step_d = '0; state_d = ST_MUL;
          end
          ReqRaw: state_d = ST_DRAW;
          ReqRanged: begin
            if ($signed(req.data.range_high) <= $signed(req.data.range_low)) begin
              val_d = req.data.range_low; out_v_d = 1'b1;
            end else if (span_w == '0) begin
              type_d = ReqRaw; state_d = ST_DRAW;
            end else begin
              // span is not registered yet, feed it straight in
              dv_start = 1'b1; dv_num = 64'd0 - span_w; dv_den = span_w;
              state_d = ST_LIM;
            end
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        prod_d = prod_q + (pp[63:0] << (dig_q * 16));
        dig_d  = dig_q + 2'd1;
        if (dig_q == 2'd3) state_d = ST_SEED_MIX;
      end
      ST_SEED_MIX: begin
        // step 0: acc ^= inst*gamma; then per word: mul A, mul B, finish
        dig_d = '0; prod_d = '0; state_d = ST_MUL;
        case (step_q[1:0])
          2'd0: begin
            if (step_q == 4'd0) acc_d = (acc_q ^ prod_q) + GoldenGamma;
            else acc_d = acc_q + GoldenGamma;
            ma_d = (step_q == 4'd0 ? (acc_q ^ prod_q) + GoldenGamma
                                   : acc_q + GoldenGamma);
            ma_d = ma_d ^ (ma_d >> 30); mb_d = MixMulA; step_d = step_q + 4'd1;
          end
          2'd1: begin
            ma_d = z ^ (z >> 27); mb_d = MixMulB; step_d = step_q + 4'd1;
          end
          default: begin
            {s0_d, s1_d, s2_d, s3_d} = {s1_q, s2_q, s3_q, z ^ (z >> 31)};
            step_d = step_q + 4'd2;
            if (step_q == 4'd14) begin
              cnt_d = '0; val_d = '0; out_v_d = 1'b1; state_d = ST_IDLE;
            end else begin
              acc_d = acc_q + GoldenGamma;
              ma_d = (acc_q + GoldenGamma) ^ ((acc_q + GoldenGamma) >> 30);
              mb_d = MixMulA; step_d = step_q + 4'd3;
            end
          end
        endcase
      end
      ST_DRAW: begin
        d_d  = draw_res + s0_q;
        s2_d = s2_q ^ s0_q ^ (s1_q << 17);
        s3_d = {(s3_q ^ s1_q)} << 45 | (s3_q ^ s1_q) >> 19;
        s1_d = s1_q ^ s2_q ^ s0_q;
        s0_d = s0_q ^ s3_q ^ s1_q;
        cnt_d = cnt_q + 64'd1;
        if (type_q == ReqRaw) begin
          val_d = draw_res + s0_q; out_v_d = 1'b1; state_d = ST_IDLE;
        end else state_d = ST_TEST;
      end
      ST_LIM: if (dv_done) begin
        lim_d = 64'd0 - dv_rem; state_d = ST_DRAW;
      end
      ST_TEST: begin
        if (lim_q != '0 && d_q >= lim_q) state_d = ST_DRAW;
        else begin
          dv_start = 1'b1; state_d = ST_MOD;
        end
      end
      ST_MOD: if (dv_done) begin
        val_d = lo_q + dv_rem; out_v_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_v_q <= 1'b0;
      {s0_q, s1_q, s2_q, s3_q} <= '0;
      cnt_q <= '0;
      step_q <= '0;
      dig_q <= '0;
      type_q <= ReqNone;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      {s0_q, s1_q, s2_q, s3_q} <= {s0_d, s1_d, s2_d, s3_d};
      cnt_q <= cnt_d;
      step_q <= step_d;
      dig_q <= dig_d;
      type_q <= type_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; span_q <= span_d; lim_q <= lim_d; d_q <= d_d;
    acc_q <= acc_d; val_q <= val_d; ma_q <= ma_d; mb_q <= mb_d;
    prod_q <= prod_d;
  end
endmodule
`default_nettype wire

@@ hdl/xsg_checker.sv @@
// ----------------------------------------------------------------------------
// xsg_checker: port-level checks of the stream generator
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
`default_nettype none
module xsg_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic [1:0] req_type,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic [63:0] rsp_value
);
  import xsg_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
    else $error("result dropped while stalled");
  // no new request while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready)
    else $error("request taken while result pending");
  // a request that yields a result is not followed by immediate acceptance
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && req_type != ReqNone |=> !req_ready)
    else $error("two requests in flight");
endmodule

bind xoshiro_stream_generator xsg_checker u_chk (
  .clk_i, .rst_ni, .req_valid(req.valid), .req_ready(req.ready),
  .req_type(req.data.req_type),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_value(rsp.data.value)
);
`default_nettype wire

@@ verif/xoshiro_stream_generator_tb.sv @@
// ----------------------------------------------------------------------------
// xoshiro_stream_generator_tb: self-checking bench of the stream generator
// Drives seed, raw, ranged and dropped requests and root seed writes, predicts
// every result with a local xoshiro256++/SplitMix64 model and checks in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module xoshiro_stream_generator_tb;
  import xsg_pkg::*;

  localparam longint unsigned CycleLimit = 64'd3000000;
  localparam logic [63:0] SignBit = 64'h8000000000000000;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;

  xsg_stream_if #(.T(xsg_req_t)) req_ch ();
  xsg_stream_if #(.T(xsg_rsp_t)) rsp_ch ();

  xoshiro_stream_generator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req_ch.sink), .rsp(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [63:0] seed_reg;
  logic [63:0] word_q [4];
  logic [63:0] draws_q;
  xsg_rsp_t    pending_rsp [$];

  int unsigned errors;
  longint unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  function automatic logic [63:0] rotl(logic [63:0] x, int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  function automatic logic [63:0] splitmix(ref logic [63:0] acc);
    logic [63:0] z;
    acc = acc + GoldenGamma;
    z = acc;
    z = (z ^ (z >> 30)) * MixMulA;
    z = (z ^ (z >> 27)) * MixMulB;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [63:0] next_draw();
    logic [63:0] res, t;
    res = rotl(word_q[0] + word_q[3], 23) + word_q[0];
    t = word_q[1] << 17;
    word_q[2] ^= word_q[0];
    word_q[3] ^= word_q[1];
    word_q[1] ^= word_q[2];
    word_q[0] ^= word_q[3];
    word_q[2] ^= t;
    word_q[3] = rotl(word_q[3], 45);
    draws_q = draws_q + 1;
    return res;
  endfunction

  // Returns 1 when the request yields a result.
  function automatic bit predict_rsp(xsg_req_t r, output xsg_rsp_t o);
    logic [63:0] acc, span, lim, d;
    o = '0;
    case (r.req_type)
      ReqSeed: begin
        acc = seed_reg ^ r.domain_hash ^ (r.instance_number * GoldenGamma);
        for (int i = 0; i < 4; i++) word_q[i] = splitmix(acc);
        draws_q = '0;
        o.value = '0;
      end
      ReqRaw: o.value = next_draw();
      ReqRanged: begin
        if ((r.range_high ^ SignBit) <= (r.range_low ^ SignBit)) begin
          o.value = r.range_low;
        end else begin
          span = r.range_high - r.range_low + 64'd1;
          if (span == 0) begin
            o.value = next_draw();
          end else begin
            lim = 64'd0 - ((64'd0 - span) % span);
            d = next_draw();
            while (lim != 0 && d >= lim) d = next_draw();
            o.value = r.range_low + (d % span);
          end
        end
      end
      default: return 0;
    endcase
    o.draw_count = draws_q;
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("xoshiro_stream_generator_tb: errors");
      $finish;
    end
  end

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    xsg_rsp_t want;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected value", rsp_ch.data.value, '0);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_ch.data.value !== want.value)
            report_mismatch("value", rsp_ch.data.value, want.value);
          if (rsp_ch.data.draw_count !== want.draw_count)
            report_mismatch("draw_count", rsp_ch.data.draw_count, want.draw_count);
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_seed(logic [63:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    seed_reg = v;
  endtask

  // Sends one request, predicting on acceptance. valid stays up after the
  // handshake; the next send, an idle cycle or drain() takes it down.
  task automatic send_req(xsg_req_t r, bit check_fixed, logic [63:0] fixed_val);
    xsg_rsp_t o;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1;
    req_ch.data <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    if (predict_rsp(r, o)) begin
      if (check_fixed && o.value !== fixed_val)
        report_mismatch("predictor", o.value, fixed_val);
      pending_rsp = {pending_rsp, o};
    end
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    // every result has been taken by now; idle before the next step
    repeat (400) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic xsg_req_t make_req(logic [1:0] k, logic [63:0] lo, logic [63:0] hi);
    xsg_req_t r;
    r.req_type = k;
    r.domain_hash = rand64();
    r.instance_number = rand64();
    r.range_low = lo;
    r.range_high = hi;
    return r;
  endfunction

  function automatic xsg_req_t random_req();
    xsg_req_t r;
    int unsigned p, w;
    logic [63:0] lo;
    p = $urandom_range(99);
    w = $urandom_range(1, 63);
    lo = rand64();
    if (p < 6) r = make_req(ReqSeed, rand64(), rand64());
    else if (p < 8) r = make_req(ReqNone, rand64(), rand64());
    else if (p < 35) r = make_req(ReqRaw, rand64(), rand64());
    else if (p < 45) r = make_req(ReqRanged, lo, rand64());
    else if (p < 50) r = make_req(ReqRanged, lo, lo - ($urandom_range(3)));
    else if (p < 55) r = make_req(ReqRanged, lo, lo + (64'd1 << w) - 1);
    else r = make_req(ReqRanged, lo, lo + (rand64() >> w));
    if ($urandom_range(9) == 0) begin
      r.domain_hash = '1; r.instance_number = '0;
    end
    return r;
  endfunction

  typedef struct {
    xsg_req_t    r;
    bit          fixed;
    logic [63:0] val;
  } stim_row_t;

  stim_row_t dir_rows [$];

  initial begin
    logic [63:0] seeds [4];
    cycles = 0; errors = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    seed_reg = '0; draws_q = '0;
    for (int i = 0; i < 4; i++) word_q[i] = '0;
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    req_ch.valid = 0; req_ch.data = '0; rsp_ch.ready = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: unseeded draws, extremes, empty ranges, full span, seeding
    dir_rows = '{
      '{make_req(ReqRaw, 0, 0), 1, 64'd0},
      '{make_req(ReqRanged, 64'd5, 64'd100), 1, 64'd5},
      '{make_req(ReqNone, 0, 0), 0, 0},
      '{make_req(ReqSeed, 0, 0), 1, 64'd0},
      '{make_req(ReqRanged, 64'd7, 64'd7), 1, 64'd7},
      '{make_req(ReqRanged, 64'd9, 64'd3), 1, 64'd9},
      '{make_req(ReqRanged, 64'h7fffffffffffffff, SignBit), 1, 64'h7fffffffffffffff},
      '{make_req(ReqRanged, SignBit, 64'h7fffffffffffffff), 0, 0},
      '{make_req(ReqRanged, 64'd0, 64'hffffffffffffffff), 1, 64'd0},
      '{make_req(ReqRanged, SignBit, SignBit + 64'd1), 0, 0},
      '{make_req(ReqRanged, 64'd0, 64'd255), 0, 0},
      '{make_req(ReqRanged, 64'hffffffffffffff00, 64'd2), 0, 0},
      '{make_req(ReqRanged, 64'd0, 64'h4000000000000000), 0, 0},
      '{make_req(ReqRaw, 0, 0), 0, 0},
      '{make_req(ReqNone, 0, 0), 0, 0},
      '{make_req(ReqRaw, 0, 0), 0, 0}
    };
    dir_rows[3].r.domain_hash = '0; dir_rows[3].r.instance_number = '0;
    foreach (dir_rows[i]) send_req(dir_rows[i].r, dir_rows[i].fixed, dir_rows[i].val);
    drain();
    write_seed('1);
    begin
      xsg_req_t r;
      r = make_req(ReqSeed, 0, 0);
      r.domain_hash = '1; r.instance_number = '1;
      send_req(r, 1, 64'd0);
      send_req(make_req(ReqRaw, 0, 0), 0, 0);
    end
    drain();

    // random phases with different idle patterns and root seeds
    seeds = '{64'd0, 64'hffffffffffffffff, rand64(), SignBit};
    for (int ph = 0; ph < 4; ph++) begin
      write_seed(seeds[ph]);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      send_req(make_req(ReqSeed, 0, 0), 1, 64'd0);
      for (int n = 0; n < 480; n++) send_req(random_req(), 0, 0);
      drain();
    end

    if (errors == 0) begin
      $display("xoshiro_stream_generator_tb: clean");
    end else begin
      $display("xoshiro_stream_generator_tb: errors");
    end
    $finish;
  end
endmodule
